FILE: rtl/core/wac_pkg.sv
// Shared types and constants of the windowed average framer.
`default_nettype none

package wac_pkg;

	// Register indexes of the configuration port.
	localparam logic [1:0] REG_SAMPLING_WINDOW = 2'd0;
	localparam logic [1:0] REG_IDLE_WINDOW     = 2'd1;
	localparam logic [1:0] REG_SAMPLE_INTERVAL = 2'd2;
	localparam logic [1:0] REG_HEADER          = 2'd3;

	// Register values after reset.
	localparam logic [15:0] SAMPLING_WINDOW_RST = 16'd5000;
	localparam logic [15:0] IDLE_WINDOW_RST     = 16'd5000;
	localparam logic [15:0] SAMPLE_INTERVAL_RST = 16'd1;
	localparam logic [7:0]  HEADER_RST          = 8'hAA;

	localparam logic [15:0] COUNT_MAX = 16'hFFFF;

	// CRC-8 setup over the float bytes.
	localparam logic [7:0] CRC_INIT = 8'hFF;
	localparam logic [7:0] CRC_POLY = 8'h31;

	// Width of the average magnitude; it never exceeds 2^15.
	localparam int unsigned MAG_W = 17;

	// Exponent bias plus the top bit position of the magnitude (value is Q8.8).
	localparam logic [7:0] EXP_START = 8'd135;

	// Request from the sequencer to the packet formatter.
	typedef struct packed {
		logic             sign;
		logic [MAG_W-1:0] mag;
		logic [7:0]       header;
	} fmt_req_t;

endpackage

`default_nettype wire

FILE: rtl/core/wac_div.sv
// Restoring divider, one quotient bit per cycle, for the window average.
`default_nettype none

module wac_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [31:0]                dividend,
	input  logic [15:0]                divisor,
	output logic                       done,
	output logic [wac_pkg::MAG_W-1:0]  quotient
);

	logic        busy_q;
	logic        done_q;
	logic [4:0]  step_q;
	logic [31:0] dq_q;
	logic [15:0] rem_q;
	logic [15:0] div_q;

	logic [16:0] rem_sh;
	logic [16:0] rem_sub;
	logic        fits;

	// Shift in the next dividend bit and try one subtraction.
	// The partial remainder stays below the divisor, so 16 bits hold it.
	assign rem_sh  = {rem_q, dq_q[31]};
	assign fits    = rem_sh >= {1'b0, div_q};
	assign rem_sub = rem_sh - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 5'd1;
				if (step_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? rem_sub[15:0] : rem_sh[15:0];
			dq_q  <= {dq_q[30:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = dq_q[wac_pkg::MAG_W-1:0];

endmodule

`default_nettype wire

FILE: rtl/core/wac_tx.sv
// Packet formatter: float normalization by shifting, CRC-8 and byte output register.
`default_nettype none

module wac_tx (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  wac_pkg::fmt_req_t req,
	output logic              done,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [7:0]        m_tdata,
	output logic              m_tlast
);

	typedef enum logic [2:0] {
		T_IDLE = 3'b001,
		T_NORM = 3'b010,
		T_EMIT = 3'b100
	} tx_state_t;

	localparam logic [2:0] BYTE_HDR = 3'd0;
	localparam logic [2:0] BYTE_F0  = 3'd1;
	localparam logic [2:0] BYTE_F1  = 3'd2;
	localparam logic [2:0] BYTE_F2  = 3'd3;
	localparam logic [2:0] BYTE_F3  = 3'd4;
	localparam logic [2:0] BYTE_CRC = 3'd5;

	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			c = c[7] ? ({c[6:0], 1'b0} ^ wac_pkg::CRC_POLY) : {c[6:0], 1'b0};
		end
		return c;
	endfunction

	tx_state_t                 state_q;
	logic                      sign_q;
	logic                      zero_q;
	logic [wac_pkg::MAG_W-1:0] man_q;
	logic [7:0]                exp_q;
	logic [7:0]                hdr_q;
	logic [2:0]                idx_q;
	logic [7:0]                crc_q;
	logic                      done_q;
	logic                      valid_q;
	logic [7:0]                data_q;
	logic                      last_q;

	logic [31:0] flt;
	logic        slot_free;
	logic [7:0]  next_byte;

	// The top magnitude bit is implicit, the rest fills the mantissa from the top.
	assign flt = zero_q ? 32'd0 :
		{sign_q, exp_q, man_q[wac_pkg::MAG_W-2:0], {(24 - wac_pkg::MAG_W){1'b0}}};

	assign slot_free = !valid_q || m_tready;

	always_comb begin
		unique case (idx_q)
			BYTE_HDR: next_byte = hdr_q;
			BYTE_F0:  next_byte = flt[7:0];
			BYTE_F1:  next_byte = flt[15:8];
			BYTE_F2:  next_byte = flt[23:16];
			BYTE_F3:  next_byte = flt[31:24];
			default:  next_byte = crc_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
			idx_q   <= BYTE_HDR;
			done_q  <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (valid_q && m_tready) begin
				valid_q <= 1'b0;
			end
			unique case (state_q)
				T_IDLE: begin
					if (start) begin
						idx_q   <= BYTE_HDR;
						state_q <= (req.mag == '0) ? T_EMIT : T_NORM;
					end
				end
				T_NORM: begin
					if (man_q[wac_pkg::MAG_W-1]) begin
						state_q <= T_EMIT;
					end
				end
				T_EMIT: begin
					if (slot_free) begin
						valid_q <= 1'b1;
						idx_q   <= idx_q + 3'd1;
						if (idx_q == BYTE_CRC) begin
							state_q <= T_IDLE;
							done_q  <= 1'b1;
						end
					end
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == T_IDLE && start) begin
			sign_q <= req.sign;
			zero_q <= (req.mag == '0);
			man_q  <= req.mag;
			exp_q  <= wac_pkg::EXP_START;
			hdr_q  <= req.header;
			crc_q  <= wac_pkg::CRC_INIT;
		end else if (state_q == T_NORM && !man_q[wac_pkg::MAG_W-1]) begin
			man_q <= {man_q[wac_pkg::MAG_W-2:0], 1'b0};
			exp_q <= exp_q - 8'd1;
		end else if (state_q == T_EMIT && slot_free) begin
			data_q <= next_byte;
			last_q <= (idx_q == BYTE_CRC);
			if (idx_q != BYTE_HDR && idx_q != BYTE_CRC) begin
				crc_q <= crc8_step(crc_q, next_byte);
			end
		end
	end

	assign done     = done_q;
	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;
	assign m_tlast  = last_q;

endmodule

`default_nettype wire

FILE: rtl/core/windowed_average_crc8_framer.sv
// Top level of the windowed average framer with CRC-8 packets.
//
// Each slave-side transaction is one millisecond tick: s_tdata[15:0] carries a
// signed Q8.8 temperature and s_tuser says whether the reading is a number.
// The block cycles through sampling, sending and idle modes on these ticks.
// A tick that produces no packet does not drop s_tready, so the slave side
// stays ready for the next tick.
// The sending tick with samples starts a 32-step serial divide of the sum by
// the count, then a shift normalizer turns the average into an IEEE single
// (skipped for a zero average), and six bytes leave through the master side:
// header, float bytes low first, and the CRC-8 with m_tlast set.
// The slave side is held off from that tick until the last byte is loaded into
// the output register.
// A stall on m_tready holds the current byte and delays the rest; the tick
// after the packet can be accepted while the last byte still waits.
// Registers are written through cfg_we, cfg_index and cfg_data at any edge.
// Reset clears the tick counter, sums and mode to sampling and loads the
// default window, interval and header values.
`default_nettype none

module windowed_average_crc8_framer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] sample_value
	input  logic        s_tuser,   // [0] sample_valid
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] packet_byte
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	// Operating mode of the tick cycle.
	typedef enum logic [2:0] {
		M_SAMPLING = 3'b001,
		M_SENDING  = 3'b010,
		M_IDLE     = 3'b100
	} mode_t;

	// Sequencer around the divider and the formatter.
	typedef enum logic [2:0] {
		S_RUN = 3'b001,
		S_DIV = 3'b010,
		S_TX  = 3'b100
	} seq_t;

	logic [15:0] sampling_window_q;
	logic [15:0] idle_window_q;
	logic [15:0] sample_interval_q;
	logic [7:0]  header_q;

	mode_t       mode_q;
	seq_t        seq_q;
	logic [31:0] now_q;
	logic [31:0] start_tick_q;
	logic [31:0] last_sample_q;
	logic [31:0] sum_q;
	logic [15:0] count_q;
	logic        sign_q;

	logic        accept;
	logic [31:0] since_sample;
	logic [31:0] since_start;
	logic        div_start;
	logic [31:0] div_dividend;
	logic        div_done;
	logic [wac_pkg::MAG_W-1:0] quotient;
	logic        tx_start;
	logic        tx_done;
	wac_pkg::fmt_req_t tx_req;

	assign s_tready = (seq_q == S_RUN);
	assign accept   = s_tvalid && s_tready;

	// Elapsed times are plain 32-bit differences, so the tick counter may wrap.
	assign since_sample = now_q - last_sample_q;
	assign since_start  = now_q - start_tick_q;

	// The sending tick divides the magnitude of the sum; the sign is kept apart.
	assign div_start    = accept && mode_q == M_SENDING && count_q != '0;
	assign div_dividend = sum_q[31] ? (32'd0 - sum_q) : sum_q;

	assign tx_start    = (seq_q == S_DIV) && div_done;
	assign tx_req.sign = sign_q;
	assign tx_req.mag  = quotient;
	assign tx_req.header = header_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sampling_window_q <= wac_pkg::SAMPLING_WINDOW_RST;
			idle_window_q     <= wac_pkg::IDLE_WINDOW_RST;
			sample_interval_q <= wac_pkg::SAMPLE_INTERVAL_RST;
			header_q          <= wac_pkg::HEADER_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				wac_pkg::REG_SAMPLING_WINDOW: sampling_window_q <= cfg_data;
				wac_pkg::REG_IDLE_WINDOW:     idle_window_q     <= cfg_data;
				wac_pkg::REG_SAMPLE_INTERVAL: sample_interval_q <= cfg_data;
				default:                      header_q          <= cfg_data[7:0];
			endcase
		end
	end

	// Sequencer: a packet tick holds the slave side until the formatter is done.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= S_RUN;
		end else begin
			unique case (seq_q)
				S_RUN:   if (div_start) seq_q <= S_DIV;
				S_DIV:   if (div_done) seq_q <= S_TX;
				S_TX:    if (tx_done) seq_q <= S_RUN;
				default: seq_q <= S_RUN;
			endcase
		end
	end

	// Tick processing of the three modes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= M_SAMPLING;
			now_q         <= '0;
			start_tick_q  <= '0;
			last_sample_q <= '0;
			sum_q         <= '0;
			count_q       <= '0;
			sign_q        <= 1'b0;
		end else if (accept) begin
			now_q <= now_q + 32'd1;
			unique case (mode_q)
				M_SAMPLING: begin
					if (since_sample >= {16'd0, sample_interval_q}) begin
						// A full count stops taking samples, so the sum cannot overflow.
						if (s_tuser && count_q != wac_pkg::COUNT_MAX) begin
							sum_q   <= sum_q + {{16{s_tdata[15]}}, s_tdata};
							count_q <= count_q + 16'd1;
						end
						last_sample_q <= now_q;
					end
					if (since_start >= {16'd0, sampling_window_q}) begin
						mode_q       <= M_SENDING;
						start_tick_q <= now_q;
					end
				end
				M_SENDING: begin
					sign_q       <= sum_q[31];
					sum_q        <= '0;
					count_q      <= '0;
					mode_q       <= M_IDLE;
					start_tick_q <= now_q;
				end
				M_IDLE: begin
					if (since_start >= {16'd0, idle_window_q}) begin
						mode_q       <= M_SAMPLING;
						start_tick_q <= now_q;
					end
				end
				default: begin
					mode_q       <= M_SAMPLING;
					start_tick_q <= now_q;
				end
			endcase
		end
	end

	wac_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (count_q),
		.done     (div_done),
		.quotient (quotient)
	);

	wac_tx u_tx (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (tx_start),
		.req      (tx_req),
		.done     (tx_done),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for the windowed average framer with CRC-8 packets.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	// Mode of the tick sequencer as tracked by the predictor.
	typedef enum logic [1:0] {
		MODE_SAMPLING = 2'd0,
		MODE_SENDING  = 2'd1,
		MODE_IDLE     = 2'd2
	} tick_mode_t;

	// One expected byte on the master side.
	typedef struct {
		logic [7:0] pkt_byte;
		logic       is_last;
	} packet_item_t;

	// Cycles to let pass after the last expected byte before touching registers.
	localparam int SETTLE_CYCLES    = 4;
	// Quiet cycles at the very end.
	localparam int DRAIN_CYCLES     = 64;
	// Length of the deliberate output hold-off.
	localparam int LONG_HOLD_CYCLES = 400;
	// The watchdog fires after this many cycles without any transaction.
	localparam int STALL_LIMIT      = 4000;
	localparam int RANDOM_PHASES    = 6;
	localparam int PHASE_TICKS      = 24;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata   = '0;   // [15:0] sample_value
	logic        s_tuser   = 1'b0; // [0] sample_valid
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [7:0]  m_tdata;          // [7:0] packet_byte
	logic        m_tlast;
	logic        cfg_we    = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data  = '0;

	windowed_average_crc8_framer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Bytes the predictor has produced that have not yet left the block.
	packet_item_t expected_bytes[$];
	packet_item_t head_item;
	int error_count = 0;
	int quiet_cycles = 0;

	// Traffic shaping controls shared between the tests and the receiver.
	bit tx_steady = 1'b0;
	bit rx_steady = 1'b0;
	bit long_hold_req = 1'b0;
	int hold_left = 0;

	// Predictor copy of the registers.
	logic [15:0] win_sampling;
	logic [15:0] win_idle;
	logic [15:0] take_interval;
	logic [7:0]  hdr_value;

	// Predictor copy of the sequencer state.
	tick_mode_t  cur_mode;
	logic [31:0] tick_count;
	logic [31:0] mode_begin;
	logic [31:0] last_take;
	logic [31:0] temp_sum;
	logic [15:0] take_count;

	// Idle lengths: mostly none or short, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Random sample that leans on the two extremes now and then.
	function automatic logic [15:0] rand_sample();
		case ($urandom_range(0, 9))
			0: return 16'h7FFF;
			1: return 16'h8000;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	// Most readings are numbers; some come from a sensor that reported NaN.
	function automatic logic rand_ok();
		return $urandom_range(0, 99) < 85;
	endfunction

	// Exact conversion of a Q8.8 value to the bits of an IEEE single.
	// The magnitude never exceeds 2^15, so the mantissa is never rounded.
	function automatic logic [31:0] q88_to_float_bits(input int q);
		logic [16:0] mag;
		logic [39:0] wide;
		logic [31:0] bits;
		int msb;
		if (q == 0)
			return 32'h0;
		mag = (q < 0) ? 17'(-q) : 17'(q);
		msb = 0;
		for (int i = 0; i < 17; i++)
			if (mag[i])
				msb = i;
		wide = {23'b0, mag} << (23 - msb);
		bits[31] = (q < 0);
		bits[30:23] = 8'(msb + 119);
		bits[22:0] = wide[22:0];
		return bits;
	endfunction

	// CRC-8 over one byte, MSB first, no reflection.
	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		c = crc ^ data;
		for (int i = 0; i < 8; i++)
			c = c[7] ? ((c << 1) ^ wac_pkg::CRC_POLY) : (c << 1);
		return c;
	endfunction

	task automatic reset_predictor();
		win_sampling = wac_pkg::SAMPLING_WINDOW_RST;
		win_idle = wac_pkg::IDLE_WINDOW_RST;
		take_interval = wac_pkg::SAMPLE_INTERVAL_RST;
		hdr_value = wac_pkg::HEADER_RST;
		cur_mode = MODE_SAMPLING;
		tick_count = '0;
		mode_begin = '0;
		last_take = '0;
		temp_sum = '0;
		take_count = '0;
	endtask

	// Advances the predictor by one tick and queues any packet that it causes.
	task automatic predict_tick(input logic [15:0] value, input logic ok);
		logic [31:0] now;
		logic [31:0] fbits;
		logic [7:0]  crc;
		logic [7:0]  b;
		int avg;
		now = tick_count;
		case (cur_mode)
			MODE_SAMPLING: begin
				// The interval check updates the take time even when the
				// reading is not a number.
				if (now - last_take >= 32'(take_interval)) begin
					if (ok && take_count != wac_pkg::COUNT_MAX) begin
						temp_sum = temp_sum + {{16{value[15]}}, value};
						take_count = take_count + 16'd1;
					end
					last_take = now;
				end
				if (now - mode_begin >= 32'(win_sampling)) begin
					cur_mode = MODE_SENDING;
					mode_begin = now;
				end
			end
			MODE_SENDING: begin
				if (take_count != 16'd0) begin
					// Signed division truncates toward zero.
					avg = $signed(temp_sum) / int'(take_count);
					fbits = q88_to_float_bits(avg);
					expected_bytes.push_back('{hdr_value, 1'b0});
					crc = wac_pkg::CRC_INIT;
					for (int k = 0; k < 4; k++) begin
						b = fbits[8*k +: 8];
						crc = crc8_step(crc, b);
						expected_bytes.push_back('{b, 1'b0});
					end
					expected_bytes.push_back('{crc, 1'b1});
				end
				temp_sum = '0;
				take_count = '0;
				cur_mode = MODE_IDLE;
				mode_begin = now;
			end
			MODE_IDLE: begin
				if (now - mode_begin >= 32'(win_idle)) begin
					cur_mode = MODE_SAMPLING;
					mode_begin = now;
				end
			end
			default: begin
				cur_mode = MODE_SAMPLING;
				mode_begin = now;
			end
		endcase
		tick_count = now + 32'd1;
	endtask

	// Offers one tick on the slave side and waits for its transaction.
	// It is called at a rising edge and returns at the accepting edge with
	// s_tvalid still high, so back-to-back ticks need no extra cycle.
	task automatic send_tick(input logic [15:0] value, input logic ok);
		int gap;
		gap = tx_steady ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= value;
		s_tuser <= ok;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predict_tick(value, ok);
	endtask

	// Stops the sender and waits until every expected byte has left the block.
	// A tick without a packet may still be settling, hence the extra cycles.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_bytes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One register write; the enable drops for a cycle between writes.
	task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			wac_pkg::REG_SAMPLING_WINDOW: win_sampling = value;
			wac_pkg::REG_IDLE_WINDOW: win_idle = value;
			wac_pkg::REG_SAMPLE_INTERVAL: take_interval = value;
			wac_pkg::REG_HEADER: hdr_value = value[7:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// Writes all four registers once the block is idle. The unused upper
	// bits of the header write carry random junk that must be ignored.
	task automatic configure(input logic [15:0] sampling, input logic [15:0] idle,
			input logic [15:0] interval, input logic [7:0] header);
		wait_idle();
		write_reg(wac_pkg::REG_SAMPLING_WINDOW, sampling);
		write_reg(wac_pkg::REG_IDLE_WINDOW, idle);
		write_reg(wac_pkg::REG_SAMPLE_INTERVAL, interval);
		write_reg(wac_pkg::REG_HEADER, {8'($urandom), header});
	endtask

	// Two chosen samples form one sampling window of two ticks; the sending
	// and idle ticks that follow carry random content that must be ignored.
	task automatic send_pair(input logic [15:0] a, input logic a_ok,
			input logic [15:0] b, input logic b_ok);
		send_tick(a, a_ok);
		send_tick(b, b_ok);
		while (cur_mode != MODE_SAMPLING)
			send_tick(rand_sample(), rand_ok());
	endtask

	// A short first window right after reset. The header keeps its reset
	// value here, so the packet also checks it.
	task automatic test_reset_header();
		write_reg(wac_pkg::REG_SAMPLING_WINDOW, 16'd3);
		write_reg(wac_pkg::REG_SAMPLE_INTERVAL, 16'h0000);
		write_reg(wac_pkg::REG_IDLE_WINDOW, 16'h0000);
		while (cur_mode != MODE_IDLE)
			send_tick(rand_sample(), 1'b1);
	endtask

	// Extremes of the average, zero, truncation and empty windows.
	task automatic test_directed_frames();
		configure(16'd2, 16'd0, 16'd0, 8'hFF);
		while (cur_mode != MODE_SAMPLING)
			send_tick(rand_sample(), rand_ok());
		send_pair(16'h7FFF, 1'b1, 16'h7FFF, 1'b1);
		send_pair(16'h8000, 1'b1, 16'h8000, 1'b1);
		// Opposite readings average to zero, which packs as all-zero float bytes.
		send_pair(16'h0001, 1'b1, 16'hFFFF, 1'b1);
		// Minus three over two truncates to minus one, not minus two.
		send_pair(16'hFFFD, 1'b1, 16'h0000, 1'b1);
		// No reading is a number, so the sending tick emits nothing.
		send_pair(16'h1234, 1'b0, 16'h4321, 1'b0);
		send_pair(16'h1234, 1'b1, 16'h7FFF, 1'b0);
	endtask

	// Largest windows and interval with a zero header; a few ticks only.
	task automatic test_register_extremes();
		configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'h00);
		repeat (6)
			send_tick(rand_sample(), rand_ok());
	endtask

	// The receiver holds off for a long stretch while the sender keeps
	// offering ticks, so the packet stalls and the slave side backs up.
	task automatic test_output_stall();
		configure(16'd2, 16'd0, 16'd0, 8'($urandom));
		long_hold_req = 1'b1;
		while (expected_bytes.size() == 0)
			send_tick(rand_sample(), 1'b1);
		repeat (4)
			send_tick(rand_sample(), rand_ok());
	endtask

	// Random ticks under a series of random settings. One phase uses zero
	// windows, one runs with no idling at all, and one pauses the sender
	// half way until every pending byte has arrived.
	task automatic test_random_traffic();
		logic [15:0] sampling;
		logic [15:0] idle;
		logic [7:0]  header;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			sampling = 16'($urandom_range(0, 12));
			idle = 16'($urandom_range(0, 4));
			header = 8'($urandom);
			if (phase == 0)
				header = 8'h00;
			if (phase == 1)
				header = 8'hFF;
			if (phase == 2) begin
				sampling = 16'd0;
				idle = 16'd0;
			end
			configure(sampling, idle, 16'($urandom_range(0, 3)), header);
			tx_steady = (phase == 3);
			rx_steady = (phase == 3);
			for (int i = 0; i < PHASE_TICKS; i++) begin
				send_tick(rand_sample(), rand_ok());
				if (phase == 4 && i == PHASE_TICKS / 2)
					wait_idle();
			end
			tx_steady = 1'b0;
			rx_steady = 1'b0;
		end
	endtask

	// Receiver: random stalls of varied length, or one long hold-off on
	// request, counted here cycle by cycle.
	always @(posedge clk) begin
		if (long_hold_req) begin
			long_hold_req = 1'b0;
			hold_left = LONG_HOLD_CYCLES;
		end else if (hold_left > 0) begin
			hold_left--;
		end else if (!rx_steady && $urandom_range(0, 3) == 0) begin
			hold_left = pick_gap();
		end
		m_tready <= (hold_left == 0);
	end

	// Every master-side transaction is compared with the oldest expected byte.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_bytes.size() == 0) begin
				$display("%0t: unexpected packet byte: expected none actual %h last %b",
					$time, m_tdata, m_tlast);
				error_count++;
			end else begin
				head_item = expected_bytes.pop_front();
				if (m_tdata !== head_item.pkt_byte) begin
					$display("%0t: packet byte mismatch: expected %h actual %h",
						$time, head_item.pkt_byte, m_tdata);
					error_count++;
				end
				if (m_tlast !== head_item.is_last) begin
					$display("%0t: last flag mismatch: expected %b actual %b",
						$time, head_item.is_last, m_tlast);
					error_count++;
				end
			end
		end
	end

	// Watchdog: the run ends if no transaction happens on either side for
	// far longer than the slowest legal stretch.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		reset_predictor();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_header();
		test_directed_frames();
		test_register_extremes();
		test_output_stall();
		test_random_traffic();
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
